// ===== sv/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Types, constants and helpers shared by the point transform pipeline.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int NumRegs   = 8;
  localparam int IdxW      = 4;
  localparam int CfgW      = 64;
  localparam int ElemW     = 32;
  localparam int FracW     = 16;
  localparam int ProdW     = 2 * ElemW - FracW;   // product after the Q16 shift
  localparam int SumW      = ProdW + 2;           // room for four addends
  localparam int DivBits   = ElemW + FracW;       // quotient bits, one per stage
  localparam int NumLanes  = 3;

  localparam logic signed [ElemW-1:0] ElemMax = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic signed [ElemW-1:0] ElemMin = {1'b1, {(ElemW-1){1'b0}}};

  typedef struct packed {
    logic signed [ElemW-1:0] in_x;
    logic signed [ElemW-1:0] in_y;
    logic signed [ElemW-1:0] in_z;
    logic                    direction_only;
  } hpt_in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] out_x;
    logic signed [ElemW-1:0] out_y;
    logic signed [ElemW-1:0] out_z;
    logic                    w_was_zero;
    logic                    overflowed;
  } hpt_out_t;

  // sideband that travels with each request through the stages
  typedef struct packed {
    logic valid;
    logic dir;
    logic ovf;
  } hpt_ctl_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [ElemW-1:0] val;
  } hpt_sat_t;

  typedef logic [3:0][3:0][ElemW-1:0] hpt_mat_t;

  function automatic hpt_sat_t sat_elem(input logic signed [SumW-1:0] v);
    hpt_sat_t r;
    if (v > SumW'(ElemMax)) begin
      r.ovf = 1'b1;
      r.val = ElemMax;
    end else if (v < SumW'(ElemMin)) begin
      r.ovf = 1'b1;
      r.val = ElemMin;
    end else begin
      r.ovf = 1'b0;
      r.val = v[ElemW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/homogeneous_point_transform_unit.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform_unit
// 4x4 Q16.16 vertex transform with perspective divide.
// ----------------------------------------------------------------------------
//  channel | ports                           | transfer
//  input   | in_valid, in_ready, in_data     | valid and ready high
//  result  | out_valid, out_ready, out_data  | valid and ready high
//  config  | cfg_we, cfg_index, cfg_wdata    | cfg_we high
//
//  One vertex per cycle while the skid register is empty; stages: product,
//  row sum, divider prep, 48 quotient bit stages and the result register.
//  A skid register behind the result stage takes a request the sink refuses;
//  while it is full the whole pipeline holds. Reset loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_unit
  import hpt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hpt_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hpt_out_t        out_data,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_wdata
);

  logic [CfgW-1:0]         mat_r [NumRegs];
  hpt_mat_t                mat;
  logic                    en;
  hpt_ctl_t                ctl_in;
  hpt_ctl_t                sum_ctl;
  logic signed [ElemW-1:0] num [NumLanes];
  logic signed [ElemW-1:0] w_sum;
  logic                    last_valid;
  hpt_out_t                last_data;
  logic                    skid_full_r;
  logic                    skid_full_nxt;
  hpt_out_t                skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= CfgW'(1 << FracW);
      mat_r[1] <= '0;
      mat_r[2] <= CfgW'(1 << FracW) << ElemW;
      mat_r[3] <= '0;
      mat_r[4] <= '0;
      mat_r[5] <= CfgW'(1 << FracW);
      mat_r[6] <= '0;
      mat_r[7] <= CfgW'(1 << FracW) << ElemW;
    end else if (cfg_we && cfg_index < IdxW'(NumRegs)) begin
      mat_r[cfg_index[$clog2(NumRegs)-1:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = mat_r[2*r][ElemW-1:0];
      mat[r][1] = mat_r[2*r][CfgW-1:ElemW];
      mat[r][2] = mat_r[2*r+1][ElemW-1:0];
      mat[r][3] = mat_r[2*r+1][CfgW-1:ElemW];
    end
  end

  assign en       = ~skid_full_r;
  assign in_ready = en;

  always_comb begin
    ctl_in.valid = in_valid;
    ctl_in.dir   = in_data.direction_only;
    ctl_in.ovf   = 1'b0;
  end

  hpt_rowsum u_rowsum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (ctl_in),
    .vec     (in_data),
    .mat     (mat),
    .ctl_out (sum_ctl),
    .num     (num),
    .w_sum   (w_sum)
  );

  hpt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (sum_ctl),
    .num       (num),
    .w_sum     (w_sum),
    .res_valid (last_valid),
    .res       (last_data)
  );

  // catch the refused request as the pipeline advances over it
  always_comb begin
    if (skid_full_r) begin
      skid_full_nxt = ~out_ready;
    end else begin
      skid_full_nxt = last_valid & ~out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else begin
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_r <= last_data;
    end
  end

  assign out_valid = skid_full_r | last_valid;
  assign out_data  = skid_full_r ? skid_r : last_data;

`ifndef NO_ASSERTIONS
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(last_valid && !out_ready))
    else $error("skid filled without a refused request");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r && !out_ready |=> skid_full_r && $stable(skid_r))
    else $error("skid request lost while stalled");

  a_wzero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.w_was_zero |->
      (out_data.out_x == '0 || out_data.out_x == ElemMax || out_data.out_x == ElemMin))
    else $error("zero w result not saturated");
`endif

endmodule

// ===== sv/hpt_rowsum.sv =====
// ----------------------------------------------------------------------------
// hpt_rowsum
// Two stages: the twelve matrix products, then the four saturated row sums.
// ----------------------------------------------------------------------------
module hpt_rowsum
  import hpt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  hpt_ctl_t                ctl_in,
  input  hpt_in_t                 vec,
  input  hpt_mat_t                mat,
  output hpt_ctl_t                ctl_out,
  output logic signed [ElemW-1:0] num [NumLanes],
  output logic signed [ElemW-1:0] w_sum
);

  logic signed [2*ElemW-1:0] prod [4][3];
  logic signed [ElemW-1:0]   v [3];
  logic signed [ProdW-1:0]   prod_r [4][3];
  logic signed [ElemW-1:0]   col3_r [4];
  hpt_ctl_t                  s1_ctl_r;
  logic signed [SumW-1:0]    sum [4];
  hpt_sat_t                  sat [4];
  logic signed [ElemW-1:0]   num_r [NumLanes];
  logic signed [ElemW-1:0]   w_r;
  hpt_ctl_t                  s2_ctl_r;
  hpt_ctl_t                  s2_ctl_nxt;

  assign v[0] = vec.in_x;
  assign v[1] = vec.in_y;
  assign v[2] = vec.in_z;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = $signed(mat[r][c]) * v[c];
      end
    end
  end

  // floor shift by the fraction width: keep the upper product bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= prod[r][c][2*ElemW-1:FracW];
        end
        col3_r[r] <= vec.direction_only ? '0 : $signed(mat[r][3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r.valid <= ctl_in.valid;
      s1_ctl_r.dir   <= vec.direction_only;
      s1_ctl_r.ovf   <= 1'b0;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = SumW'(prod_r[r][0]) + SumW'(prod_r[r][1]) + SumW'(prod_r[r][2])
             + SumW'(col3_r[r]);
      sat[r] = sat_elem(sum[r]);
    end
    s2_ctl_nxt       = s1_ctl_r;
    // w only counts in point mode
    s2_ctl_nxt.ovf   = sat[0].ovf | sat[1].ovf | sat[2].ovf | (~s1_ctl_r.dir & sat[3].ovf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NumLanes; r++) begin
        num_r[r] <= sat[r].val;
      end
      w_r <= sat[3].val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (en) begin
      s2_ctl_r <= s2_ctl_nxt;
    end
  end

  assign ctl_out = s2_ctl_r;
  assign num     = num_r;
  assign w_sum   = w_r;

endmodule

// ===== sv/hpt_div.sv =====
// ----------------------------------------------------------------------------
// hpt_div
// Perspective divide: sign split, one quotient bit per stage for the three
// lanes, then sign restore, saturation and mode selection.
// ----------------------------------------------------------------------------
module hpt_div
  import hpt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  hpt_ctl_t                ctl_in,
  input  logic signed [ElemW-1:0] num [NumLanes],
  input  logic signed [ElemW-1:0] w_sum,
  output logic                    res_valid,
  output hpt_out_t                res
);

  // stage 0 is the prep register, stage DivBits holds the finished quotient
  hpt_ctl_t                ctl_r  [DivBits+1];
  logic                    wz_r   [DivBits+1];
  logic [ElemW-1:0]        aw_r   [DivBits+1];
  logic [ElemW-1:0]        rem_r  [DivBits+1][NumLanes];
  logic [DivBits-1:0]      dq_r   [DivBits+1][NumLanes];
  logic                    neg_r  [DivBits+1][NumLanes];
  logic signed [ElemW-1:0] num_r  [DivBits+1][NumLanes];

  logic [ElemW-1:0]        an [NumLanes];
  logic [ElemW-1:0]        aw;
  logic [DivBits-1:0]      q [NumLanes];
  logic signed [ElemW-1:0] val [NumLanes];
  logic [NumLanes-1:0]     qsat;
  hpt_out_t                res_nxt;
  hpt_out_t                res_r;
  logic                    res_valid_r;

  always_comb begin
    aw = w_sum[ElemW-1] ? ElemW'(-w_sum) : ElemW'(w_sum);
    for (int l = 0; l < NumLanes; l++) begin
      an[l] = num[l][ElemW-1] ? ElemW'(-num[l]) : ElemW'(num[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz_r[0] <= ~ctl_in.dir & (w_sum == '0);
      aw_r[0] <= aw;
      for (int l = 0; l < NumLanes; l++) begin
        rem_r[0][l] <= '0;
        dq_r[0][l]  <= {an[l], {FracW{1'b0}}};
        neg_r[0][l] <= num[l][ElemW-1] ^ w_sum[ElemW-1];
        num_r[0][l] <= num[l];
      end
    end
  end

  for (genvar k = 1; k <= DivBits; k++) begin : g_step
    logic [ElemW:0]   trial [NumLanes];
    logic [ElemW:0]   diff  [NumLanes];
    logic [NumLanes-1:0] ge;

    always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
        trial[l] = {rem_r[k-1][l], dq_r[k-1][l][DivBits-1]};
        diff[l]  = trial[l] - {1'b0, aw_r[k-1]};
        ge[l]    = ~diff[l][ElemW];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (en) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wz_r[k] <= wz_r[k-1];
        aw_r[k] <= aw_r[k-1];
        for (int l = 0; l < NumLanes; l++) begin
          rem_r[k][l] <= ge[l] ? diff[l][ElemW-1:0] : trial[l][ElemW-1:0];
          dq_r[k][l]  <= {dq_r[k-1][l][DivBits-2:0], ge[l]};
          neg_r[k][l] <= neg_r[k-1][l];
          num_r[k][l] <= num_r[k-1][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      q[l] = dq_r[DivBits][l];
      if (ctl_r[DivBits].dir) begin
        qsat[l] = 1'b0;
        val[l]  = num_r[DivBits][l];
      end else if (wz_r[DivBits]) begin
        qsat[l] = 1'b0;
        if (num_r[DivBits][l] == '0) begin
          val[l] = '0;
        end else begin
          val[l] = num_r[DivBits][l][ElemW-1] ? ElemMin : ElemMax;
        end
      end else if (neg_r[DivBits][l]) begin
        // magnitude beyond the most negative value saturates
        qsat[l] = (q[l][DivBits-1:ElemW] != '0)
                | (q[l][ElemW-1] & (q[l][ElemW-2:0] != '0));
        val[l]  = qsat[l] ? ElemMin : -$signed(q[l][ElemW-1:0]);
      end else begin
        qsat[l] = (q[l][DivBits-1:ElemW-1] != '0);
        val[l]  = qsat[l] ? ElemMax : $signed(q[l][ElemW-1:0]);
      end
    end
    res_nxt.out_x      = val[0];
    res_nxt.out_y      = val[1];
    res_nxt.out_z      = val[2];
    res_nxt.w_was_zero = wz_r[DivBits];
    res_nxt.overflowed = ctl_r[DivBits].ovf | (|qsat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (en) begin
      res_valid_r <= ctl_r[DivBits].valid;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== verif/homogeneous_point_transform_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform_unit_tb
// Sends vertices through the 4x4 Q16.16 transform under several matrices,
// computes each expected vertex alongside and compares every returned field.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_unit_tb;
  import hpt_pkg::*;

  localparam int Drain = 80;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  hpt_in_t         in_data;
  logic            out_valid;
  logic            out_ready;
  hpt_out_t        out_data;
  logic            cfg_we;
  logic [IdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_wdata;

  logic [CfgW-1:0] mat_rows [NumRegs];
  hpt_out_t        vertex_q [$];
  int              err_cnt;
  bit              sink_idle;

  homogeneous_point_transform_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint elem_of(int r, int c);
    logic [CfgW-1:0] w;
    w = mat_rows[r*2 + c/2];
    return longint'($signed(c % 2 ? w[63:32] : w[31:0]));
  endfunction

  function automatic longint clamp32(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint row_total(int r, longint v[3], bit add_col3, ref bit ovf);
    longint acc;
    acc = 0;
    for (int c = 0; c < 3; c++)
      acc += (elem_of(r, c) * v[c]) >>> 16;
    if (add_col3)
      acc += elem_of(r, 3);
    return clamp32(acc, ovf);
  endfunction

  function automatic hpt_out_t transform_vertex(hpt_in_t p);
    hpt_out_t o;
    longint v[3];
    longint res[3];
    longint w, num, q;
    bit ovf;
    bit wz;
    ovf = 0;
    wz = 0;
    v[0] = longint'(p.in_x);
    v[1] = longint'(p.in_y);
    v[2] = longint'(p.in_z);
    if (p.direction_only) begin
      for (int r = 0; r < 3; r++)
        res[r] = row_total(r, v, 1'b0, ovf);
    end else begin
      w = row_total(3, v, 1'b1, ovf);
      for (int r = 0; r < 3; r++) begin
        num = row_total(r, v, 1'b1, ovf);
        if (w == 0) begin
          wz = 1;
          res[r] = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
        end else begin
          q = (num * 65536) / w;
          res[r] = clamp32(q, ovf);
        end
      end
    end
    o.out_x = res[0][31:0];
    o.out_y = res[1][31:0];
    o.out_z = res[2][31:0];
    o.w_was_zero = wz;
    o.overflowed = ovf;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // check each returned vertex against the oldest prediction
  always @(posedge clk) begin
    hpt_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        $display("unexpected result %h at %0t", out_data, $time);
        err_cnt++;
      end else begin
        e = vertex_q.pop_front();
        if (out_data.out_x !== e.out_x) report("out_x", out_data.out_x, e.out_x);
        if (out_data.out_y !== e.out_y) report("out_y", out_data.out_y, e.out_y);
        if (out_data.out_z !== e.out_z) report("out_z", out_data.out_z, e.out_z);
        if (out_data.w_was_zero !== e.w_was_zero)
          report("w_was_zero", out_data.w_was_zero, e.w_was_zero);
        if (out_data.overflowed !== e.overflowed)
          report("overflowed", out_data.overflowed, e.overflowed);
      end
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink stalls
  always @(posedge clk) begin
    if (!rst_n || sink_idle)
      out_ready <= 1'b1;
    else
      out_ready <= gap_len() == 0;
  end

  task automatic send_vertex(hpt_in_t p, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    repeat (g) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    vertex_q.push_back(transform_vertex(p));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= IdxW'(idx);
    cfg_wdata <= val;
    if (idx < NumRegs) mat_rows[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic hpt_in_t rand_vertex(int span);
    hpt_in_t p;
    p.in_x = span == 0 ? $urandom() : $signed($urandom_range(0, 2*span)) - span;
    p.in_y = span == 0 ? $urandom() : $signed($urandom_range(0, 2*span)) - span;
    p.in_z = span == 0 ? $urandom() : $signed($urandom_range(0, 2*span)) - span;
    p.direction_only = $urandom_range(0, 1);
    return p;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h0001_0000;
      1: return 32'h0;
      2: return $urandom();
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext [6];
    hpt_in_t p;
    ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001};
    for (int i = 0; i < 12; i++) begin
      p.in_x = ext[i % 6];
      p.in_y = ext[(i + 1) % 6];
      p.in_z = ext[(i + 3) % 6];
      p.direction_only = i[0];
      send_vertex(p);
    end
    settle();
    // zero w with numerators of each sign
    write_reg(7, 64'h0);
    write_reg(3, {32'hFFFF_0000, 32'h0});
    for (int i = 0; i < 3; i++) begin
      p = '{in_x: 32'(i - 1) <<< 16, in_y: 32'h0001_0000, in_z: 32'h0, direction_only: 1'b0};
      send_vertex(p);
    end
    settle();
    // tiny w drives the quotient out of range
    write_reg(7, {32'h0000_0001, 32'h0});
    send_vertex('{in_x: 32'h0100_0000, in_y: 32'h0, in_z: 32'h0, direction_only: 1'b0});
    send_vertex('{in_x: 32'h8000_0000, in_y: 32'h0, in_z: 32'h0, direction_only: 1'b1});
    settle();
    // writes beyond the register file are dropped
    write_reg(8, 64'hDEAD_BEEF_DEAD_BEEF);
    write_reg(15, 64'h0);
    send_vertex('{in_x: 32'h0003_0000, in_y: 32'h0002_0000, in_z: 32'h1, direction_only: 1'b0});
    settle();
  endtask

  task automatic test_random_matrices();
    hpt_in_t p;
    for (int phase = 0; phase < 10; phase++) begin
      for (int r = 0; r < NumRegs; r++) begin
        if (phase == 9)
          write_reg(r, {32'h8000_0000, 32'h7FFF_FFFF});
        else
          write_reg(r, {rand_elem(), rand_elem()});
      end
      for (int i = 0; i < 150; i++) begin
        case ($urandom_range(0, 3))
          0: p = rand_vertex(0);
          1: p = rand_vertex(32'h0010_0000);
          default: p = rand_vertex(32'h0400_0000);
        endcase
        send_vertex(p, phase == 4);
        // hold off until the pipeline has drained
        if (i == 75 && phase == 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (vertex_q.size() != 0) @(posedge clk);
        end
      end
      if (phase == 4) sink_idle = 0;
      if (phase == 3) sink_idle = 1;
      settle();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    out_ready = 1'b1;
    err_cnt   = 0;
    sink_idle = 0;
    mat_rows  = '{64'h1_0000, 64'h0, {32'h1_0000, 32'h0}, 64'h0,
                  64'h0, 64'h1_0000, 64'h0, {32'h1_0000, 32'h0}};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_matrices();
    if (err_cnt == 0 && vertex_q.size() == 0)
      $display("homogeneous_point_transform_unit_tb: clean");
    else
      $display("homogeneous_point_transform_unit_tb: errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("homogeneous_point_transform_unit_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hpt_pkg.sv
sv/hpt_rowsum.sv
sv/hpt_div.sv
sv/homogeneous_point_transform_unit.sv
verif/homogeneous_point_transform_unit_tb.sv
